>>> design/sba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sba_pkg: shared constants and helpers for the slab bitmap allocator
// Size classes, page geometry, bitmap memory layout and status codes.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int NUM_CLASSES = 9;
    localparam int MAX_PAGES   = 8;
    localparam int PAGE_BYTES  = 4096;
    localparam int MIN_SHIFT   = 3;

    // slots per page of class 0; each class row in the bitmap spans this many bytes
    localparam int SLOTS0      = PAGE_BYTES >> MIN_SHIFT;
    localparam int CLASS_BYTES = (MAX_PAGES * SLOTS0) / 8;
    localparam int MEM_DEPTH   = NUM_CLASSES * CLASS_BYTES;
    localparam int AW          = $clog2(MEM_DEPTH);
    localparam int BW          = $clog2(CLASS_BYTES);
    localparam int CW          = 4;
    localparam int SW          = $clog2(MAX_PAGES * SLOTS0) + 1;

    // a class exists only if its object size fits in a page
    localparam int PAGE_LOG   = $clog2(PAGE_BYTES);
    localparam int NUM_VALID  = (NUM_CLASSES < PAGE_LOG - MIN_SHIFT + 1) ?
                                NUM_CLASSES : (PAGE_LOG - MIN_SHIFT + 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LIMIT    = 2'd1,
        ST_BADSIZE  = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // slots per page for class c
    function automatic logic [SW-1:0] per_page(input logic [CW-1:0] c);
        per_page = SW'(SLOTS0 >> c);
    endfunction

endpackage

`default_nettype wire

>>> design/slab_bitmap_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted beat passes S_CLASS and S_PREP; an alloc then scans n bitmap
//   bytes (n up to MAX_PAGES*64 = 512 for class 0) in S_ARD, S_AWAIT and S_ACHK; a free
//   runs S_FRD, S_FWAIT and S_FCHK; an unopened page, bad size or page limit skips to S_OUT.
// Throughput: one item at a time; each scanned byte passes address, read and check
//   states on the single bitmap port. The next beat is taken the cycle after the result leaves.
// Reset: synchronous, active low; a clearing pass then zeroes the 4608-byte bitmap.
// ----------------------------------------------------------------------------
// slab_bitmap_allocator_core: slab allocator with per-class slot bitmaps
// A sequencer walks the bitmap memory one byte at a time for
// allocation and does a read-modify-write of one byte for a free.
// ----------------------------------------------------------------------------
module slab_bitmap_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [15:0] i_req_size,
    input  wire logic [3:0]  i_free_page,
    input  wire logic [11:0] i_free_offset,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [3:0]       o_size_class,
    output logic [3:0]       o_page_index,
    output logic [11:0]      o_byte_offset,
    output logic             o_page_added
);

    localparam int AW = sba_pkg::AW;
    localparam int BW = sba_pkg::BW;
    localparam int SW = sba_pkg::SW;
    localparam int CW = sba_pkg::CW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CLASS, S_PREP, S_ARD, S_AWAIT, S_ACHK,
        S_FRD, S_FWAIT, S_FCHK, S_OUT
    } t_state;

    // bitmap memory
    logic [7:0] mem [sba_pkg::MEM_DEPTH];
    logic [7:0] r_rdata;
    logic       mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    // per-class counters
    logic [3:0]    r_pages [sba_pkg::NUM_CLASSES];
    logic [SW-1:0] r_free  [sba_pkg::NUM_CLASSES];
    logic [SW-1:0] r_used  [sba_pkg::NUM_CLASSES];

    t_state        r_state;
    logic [AW-1:0] r_addr;      // clear pointer / scan address
    logic [BW-1:0] r_byte;      // byte index within class row
    logic [BW:0]   r_nbytes;    // bytes to scan
    logic          r_mode;
    logic [15:0]   r_size;
    logic [3:0]    r_fpage;
    logic [11:0]   r_foff;
    logic [CW-1:0] r_cls;
    logic          r_bad;
    logic [AW-1:0] r_base;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_opp;
    logic          r_added;
    logic          r_ovalid;
    logic [1:0]    r_status;
    logic [3:0]    r_opage;
    logic [11:0]   r_ooff;

    // first clear bit in the byte just read
    logic [2:0] first_zero;
    logic       any_zero;
    always_comb begin
        first_zero = '0;
        any_zero   = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            if (!r_rdata[k]) begin
                first_zero = 3'(k);
                any_zero   = 1'b1;
            end
        end
    end

    logic [SW-1:0] osize;      // object size, 8 << class
    logic [SW-1:0] slot_idx;   // offset / osize (power of two shift)
    logic          off_misal;
    logic [SW-1:0] fslot;
    logic [SW-1:0] aslot;
    logic [SW-1:0] page_sel;
    always_comb begin
        osize     = SW'(8) << r_cls;
        slot_idx  = SW'(r_foff >> (r_cls + CW'(sba_pkg::MIN_SHIFT)));
        off_misal = (SW'(r_foff) & (osize - SW'(1))) != '0;
        // opp is a power of two; page * opp as a shift
        fslot     = (SW'(r_fpage) << (SW'(sba_pkg::PAGE_LOG - sba_pkg::MIN_SHIFT) - SW'(r_cls)))
                    + slot_idx;
        aslot     = SW'({r_byte, first_zero});
        page_sel  = aslot >> (SW'(sba_pkg::PAGE_LOG - sba_pkg::MIN_SHIFT) - SW'(r_cls));
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        mem_ra = r_addr;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_ACHK: begin
                mem_we = any_zero;
                mem_wd = r_rdata | (8'h01 << first_zero);
            end
            S_FCHK: begin
                mem_we = r_rdata[r_slot[2:0]];
                mem_wd = r_rdata & ~(8'h01 << r_slot[2:0]);
            end
            default: ;
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_size_class  = r_cls;
    assign o_page_index  = r_opage;
    assign o_byte_offset = r_ooff;
    assign o_page_added  = r_added;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < sba_pkg::NUM_CLASSES; c++) begin
                r_pages[c] <= 4'd1;
                r_free[c]  <= sba_pkg::per_page(CW'(c));
                r_used[c]  <= '0;
            end
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(sba_pkg::MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode  <= i_mode;
                        r_size  <= i_req_size;
                        r_fpage <= i_free_page;
                        r_foff  <= i_free_offset;
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    // round up to a class; one compare per valid class
                    r_bad <= 1'b1;
                    r_cls <= '0;
                    for (int c = sba_pkg::NUM_VALID - 1; c >= 0; c--) begin
                        if (32'(r_size) <= (32'd8 << c)) begin
                            r_cls <= CW'(c);
                            r_bad <= 1'b0;
                        end
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_added <= 1'b0;
                    r_opage <= '0;
                    r_ooff  <= '0;
                    r_status <= sba_pkg::ST_OK;
                    r_opp   <= sba_pkg::per_page(r_cls);
                    r_base  <= AW'(32'(r_cls) * sba_pkg::CLASS_BYTES);
                    if (r_bad) begin
                        r_status <= sba_pkg::ST_BADSIZE;
                        r_cls    <= '0;
                        r_state  <= S_OUT;
                    end else if (!r_mode) begin
                        r_byte <= '0;
                        if (r_free[r_cls] == '0) begin
                            if (32'(r_pages[r_cls]) < sba_pkg::MAX_PAGES) begin
                                r_pages[r_cls] <= r_pages[r_cls] + 4'd1;
                                r_free[r_cls]  <= sba_pkg::per_page(r_cls);
                                r_added <= 1'b1;
                                r_state <= S_ARD;
                                r_nbytes <= (BW+1)'(((SW+8)'(r_pages[r_cls]) + 1)
                                            * (SW+8)'(sba_pkg::per_page(r_cls)) + 7 >> 3);
                            end else begin
                                r_status <= sba_pkg::ST_LIMIT;
                                r_state  <= S_OUT;
                            end
                        end else begin
                            r_state  <= S_ARD;
                            r_nbytes <= (BW+1)'(((SW+8)'(r_pages[r_cls]))
                                        * (SW+8)'(sba_pkg::per_page(r_cls)) + 7 >> 3);
                        end
                    end else begin
                        r_state <= S_FRD;
                    end
                end
                S_ARD: begin
                    r_addr  <= r_base + AW'(r_byte);
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    r_state <= S_ACHK;
                end
                S_ACHK: begin
                    // free count > 0 guarantees a clear bit below the total
                    if (any_zero) begin
                        r_free[r_cls] <= r_free[r_cls] - SW'(1);
                        r_used[r_cls] <= r_used[r_cls] + SW'(1);
                        r_opage <= page_sel[3:0];
                        r_ooff  <= 12'((aslot & (r_opp - SW'(1))) << (r_cls + CW'(3)));
                        r_state <= S_OUT;
                    end else if ((BW+1)'(r_byte) + 1'b1 >= r_nbytes) begin
                        r_status <= sba_pkg::ST_NOTFOUND;
                        r_added  <= 1'b0;
                        r_state  <= S_OUT;
                    end else begin
                        r_byte  <= r_byte + BW'(1);
                        r_state <= S_ARD;
                    end
                end
                S_FRD: begin
                    if (r_fpage >= r_pages[r_cls] || off_misal || slot_idx >= r_opp) begin
                        r_status <= sba_pkg::ST_NOTFOUND;
                        r_state  <= S_OUT;
                    end else begin
                        r_slot  <= fslot;
                        r_addr  <= r_base + AW'(fslot >> 3);
                        r_state <= S_FWAIT;
                    end
                end
                S_FWAIT: begin
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (r_rdata[r_slot[2:0]]) begin
                        r_free[r_cls] <= r_free[r_cls] + SW'(1);
                        r_used[r_cls] <= r_used[r_cls] - SW'(1);
                    end else begin
                        r_status <= sba_pkg::ST_NOTFOUND;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                    end else if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result valid outside output state");
    a_added_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_page_added) |-> o_status == sba_pkg::ST_OK)
        else $error("page added on failed alloc");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped under stall");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for slab_bitmap_allocator_core
// Drives alloc/free beats, predicts every result with a behavioral allocator
// model and checks results in order, with random idle and stall on both sides.
// ----------------------------------------------------------------------------
module tb;

    localparam int NCLS      = 9;
    localparam int NPAGES    = 8;
    localparam int SLOTS_MAX = NPAGES * 512;
    localparam int WD_LIMIT  = 200000;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  cls;
        logic [3:0]  page;
        logic [11:0] offset;
        logic        added;
    } alloc_result_t;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_valid = 1'b0, i_mode = 1'b0, i_stall = 1'b0;
    logic [15:0] i_req_size = '0;
    logic [3:0]  i_free_page = '0;
    logic [11:0] i_free_offset = '0;
    logic o_stall, o_valid, o_page_added;
    logic [1:0] o_status;
    logic [3:0] o_size_class, o_page_index;
    logic [11:0] o_byte_offset;

    slab_bitmap_allocator_core uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit          slot_used [NCLS][SLOTS_MAX];
    int unsigned open_pages [NCLS];
    int unsigned free_cnt [NCLS];
    alloc_result_t pending_results[$];
    // live objects, packed as {cls, page, offset}, for legal frees
    logic [19:0] live_objs[$];

    int errors = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_recv = 1'b0;
    int quiet_cycles = 0;

    function automatic int slots_per_page(int c);
        return 4096 >> (c + 3);
    endfunction

    function automatic alloc_result_t predict_alloc(logic mode, logic [15:0] size,
                                                    logic [3:0] fpg, logic [11:0] foff);
        alloc_result_t r;
        int c, opp, osz, tot, s, idx;
        r = '0;
        c = -1;
        for (int k = 0; k < NCLS && (8 << k) <= 4096; k++)
            if (c < 0 && size <= (8 << k)) c = k;
        if (c < 0) begin
            r.status = sba_pkg::ST_BADSIZE;
            return r;
        end
        r.cls = 4'(c);
        opp = slots_per_page(c);
        osz = 8 << c;
        if (mode == MODE_ALLOC) begin
            if (free_cnt[c] == 0) begin
                if (open_pages[c] < NPAGES) begin
                    open_pages[c]++;
                    free_cnt[c] += opp;
                    r.added = 1'b1;
                end else begin
                    r.status = sba_pkg::ST_LIMIT;
                    return r;
                end
            end
            tot = open_pages[c] * opp;
            s = 0;
            while (s < tot && slot_used[c][s]) s++;
            if (s < tot) begin
                slot_used[c][s] = 1'b1;
                free_cnt[c]--;
                r.page = 4'(s / opp);
                r.offset = 12'((s % opp) * osz);
                live_objs.push_back({4'(c), r.page, r.offset});
            end else begin
                r.status = sba_pkg::ST_NOTFOUND;
                r.added = 1'b0;
            end
        end else begin
            idx = foff / osz;
            if (fpg >= open_pages[c] || (foff % osz) != 0 || idx >= opp ||
                !slot_used[c][fpg * opp + idx]) begin
                r.status = sba_pkg::ST_NOTFOUND;
            end else begin
                slot_used[c][fpg * opp + idx] = 1'b0;
                free_cnt[c]++;
                foreach (live_objs[i])
                    if (live_objs[i] == {4'(c), fpg, foff}) begin
                        live_objs.delete(i);
                        break;
                    end
            end
        end
        return r;
    endfunction

    // valid stays high after the accepting edge; the next beat replaces it, and an
    // idle cycle or a drain lowers it
    task automatic send_beat(logic mode, logic [15:0] size, logic [3:0] fpg,
                             logic [11:0] foff);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_req_size <= size;
        i_free_page <= fpg;
        i_free_offset <= foff;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_alloc(mode, size, fpg, foff));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic alloc_size(int c);
        send_beat(MODE_ALLOC, 16'($urandom_range(c ? (4 << c) + 1 : 0, 8 << c)),
                  4'($urandom), 12'($urandom));
    endtask

    task automatic free_live();
        int k;
        logic [19:0] o;
        k = $urandom_range(live_objs.size() - 1);
        o = live_objs[k];
        send_beat(MODE_FREE, 16'(8 << o[19:16]), o[15:12], o[11:0]);
    endtask

    task automatic test_directed();
        send_beat(MODE_ALLOC, 16'd0, 4'd0, 12'd0);
        send_beat(MODE_ALLOC, 16'd8, 4'd0, 12'd0);
        send_beat(MODE_ALLOC, 16'd9, 4'd0, 12'd0);
        send_beat(MODE_ALLOC, 16'd2048, 4'd0, 12'd0);
        send_beat(MODE_ALLOC, 16'd2049, 4'd0, 12'd0);
        send_beat(MODE_ALLOC, 16'hFFFF, 4'hF, 12'hFFF);
        send_beat(MODE_FREE, 16'd4096, 4'd0, 12'd0);
        send_beat(MODE_FREE, 16'd8, 4'd0, 12'd8);
        send_beat(MODE_FREE, 16'd8, 4'd0, 12'd8);
        send_beat(MODE_FREE, 16'd8, 4'd0, 12'd4);
        send_beat(MODE_FREE, 16'd8, 4'd1, 12'd0);
        send_beat(MODE_FREE, 16'd2048, 4'd0, 12'd2048);
        send_beat(MODE_FREE, 16'd2048, 4'd0, 12'hFFF);
        send_beat(MODE_FREE, 16'd1024, 4'd15, 12'd0);
        // class 8 holds two objects per page: these allocations open further pages
        for (int k = 0; k < 9; k++) send_beat(MODE_ALLOC, 16'd1500, 4'd0, 12'd0);
        send_beat(MODE_FREE, 16'd2048, 4'd7, 12'd0);
        send_beat(MODE_ALLOC, 16'd2000, 4'd0, 12'd0);
    endtask

    task automatic test_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 50) alloc_size($urandom_range(r < 20 ? 8 : 5));
            else if (r < 85 && live_objs.size() != 0) free_live();
            else if (r < 92)
                send_beat(1'($urandom), 16'($urandom_range(2049, 65535)),
                          4'($urandom), 12'($urandom));
            else
                send_beat(1'($urandom), 16'($urandom), 4'($urandom), 12'($urandom));
        end
    endtask

    // receiver holds off while the sender keeps offering; then sender drains
    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            test_random(12);
        join
        wait_drained();
        test_random(4);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= hold_recv || (recv_stall_pct > 0 &&
                                     $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        alloc_result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_size_class !== e.cls) begin
                    $error("size_class exp %0d got %0d", e.cls, o_size_class); errors++;
                end
                if (o_page_index !== e.page) begin
                    $error("page_index exp %0d got %0d", e.page, o_page_index); errors++;
                end
                if (o_byte_offset !== e.offset) begin
                    $error("byte_offset exp %0d got %0d", e.offset, o_byte_offset);
                    errors++;
                end
                if (o_page_added !== e.added) begin
                    $error("page_added exp %0d got %0d", e.added, o_page_added); errors++;
                end
            end
        end
    end

    // watchdog; clearing pass after reset and long hold-off fit well inside
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < NCLS; c++) begin
            open_pages[c] = 1;
            free_cnt[c] = slots_per_page(c);
            for (int s = 0; s < SLOTS_MAX; s++) slot_used[c][s] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        send_idle_pct = 29; recv_stall_pct = 61;
        test_random(370);
        send_idle_pct = 61; recv_stall_pct = 29;
        test_random(370);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_backpressure();
        test_random(370);
        wait_drained();
        repeat (600) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> slab_bitmap_allocator_core.f
design/sba_pkg.sv
design/slab_bitmap_allocator_core.sv
tb/tb.sv
